// ----- hw/rtl/orb_pkg.sv -----
// orb_pkg: constants, command codes and control types for the overwriting ring buffer
// no dependencies
package orb_pkg;

  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

// ----- hw/rtl/orb_if.sv -----
// orb_in_if, orb_out_if: valid/ready channels for items and results
// depends on orb_pkg
interface orb_in_if;
  import orb_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [WIDTH-1:0] push_value;
  modport source (output valid, command, push_value, input ready);
  modport sink (input valid, command, push_value, output ready);
endinterface

interface orb_out_if;
  import orb_pkg::*;
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] read_value;
  logic             underflow;
  logic             overwrote;
  logic [CNT_W-1:0] fill_count;
  modport source (output valid, read_value, underflow, overwrote, fill_count, input ready);
  modport sink (input valid, read_value, underflow, overwrote, fill_count, output ready);
endinterface

// ----- hw/rtl/orb_ctrl.sv -----
// orb_ctrl: sequencing state machine, one transaction at a time
// depends on orb_pkg
module orb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output orb_pkg::ctrl_t ctrl
);
  import orb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: state_next = S_OUT;
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE) && !rst;
  assign out_valid = (state == S_OUT);
  assign ctrl.load = in_valid && (state == S_IDLE) && !rst;
  assign ctrl.exec = (state == S_EXEC);

endmodule

// ----- hw/rtl/orb_dp.sv -----
// orb_dp: store, head/tail pointers, fill count, capacity and result registers
// depends on orb_pkg
module orb_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  orb_pkg::ctrl_t            ctrl,
  input  logic                      cfg_we,
  input  logic [orb_pkg::CAP_W-1:0] cfg_data,
  input  logic [orb_pkg::CMD_W-1:0] command,
  input  logic [orb_pkg::WIDTH-1:0] push_value,
  output logic [orb_pkg::WIDTH-1:0] read_value,
  output logic                      underflow,
  output logic                      overwrote,
  output logic [orb_pkg::CNT_W-1:0] fill_count
);
  import orb_pkg::*;

  logic [WIDTH-1:0] store [DEPTH];
  logic [CMD_W-1:0] cmd;
  logic [WIDTH-1:0] value;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] cap_next;
  logic [PTR_W-1:0] head_adv;
  logic [PTR_W-1:0] tail_adv;
  logic             is_full;
  logic             is_empty;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] idx,
                                               input logic [CNT_W-1:0] lim);
    logic [CNT_W:0] n;
    n = {1'b0, CNT_W'(idx)} + (CNT_W+1)'(1);
    return (n >= {1'b0, lim}) ? '0 : n[PTR_W-1:0];
  endfunction

  // clamp capacity to 1..DEPTH
  always_comb begin
    if (cfg_data == '0) begin
      cap_next = CNT_W'(1);
    end else if ((CAP_W+CNT_W)'(cfg_data) > (CAP_W+CNT_W)'(DEPTH)) begin
      cap_next = CNT_W'(DEPTH);
    end else begin
      cap_next = CNT_W'(cfg_data);
    end
  end

  assign head_adv = advance(head, cap);
  assign tail_adv = advance(tail, cap);
  assign is_full  = (held >= cap);
  assign is_empty = (held == '0);

  // input latch
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd   <= command;
      value <= push_value;
    end
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      if (cmd == CMD_PUSH) begin
        store[tail] <= value;
        read_value  <= '0;
      end else if ((cmd == CMD_POP || cmd == CMD_PEEK) && !is_empty) begin
        read_value <= store[head];
      end else begin
        read_value <= '0;
      end
    end
  end

  // pointers, count and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      held       <= '0;
      cap        <= CNT_W'(DEPTH);
      underflow  <= 1'b0;
      overwrote  <= 1'b0;
      fill_count <= '0;
    end else if (cfg_we) begin
      cap  <= cap_next;
      head <= '0;
      tail <= '0;
      held <= '0;
    end else if (ctrl.exec) begin
      underflow  <= 1'b0;
      overwrote  <= 1'b0;
      fill_count <= held;
      case (cmd)
        CMD_PUSH: begin
          tail <= tail_adv;
          if (is_full) begin
            head       <= head_adv;
            held       <= cap;
            overwrote  <= 1'b1;
            fill_count <= cap;
          end else begin
            held       <= held + CNT_W'(1);
            fill_count <= held + CNT_W'(1);
          end
        end
        CMD_POP: begin
          if (is_empty) begin
            underflow <= 1'b1;
          end else begin
            head       <= head_adv;
            held       <= held - CNT_W'(1);
            fill_count <= held - CNT_W'(1);
          end
        end
        CMD_PEEK: begin
          if (is_empty) underflow <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/overwriting_ring_buffer_top.sv -----
// Ring buffer of up to 16 words of 32 bits whose capacity in use (1 to 16, reset 16) is
// set through cfg_we/cfg_data; a capacity write empties the buffer. Each item is a push,
// pop or peek and returns one result with the data, underflow and overwrite flags and
// the count after the step. A push into a full buffer replaces the oldest word. Items
// are handled one at a time: the item is latched on acceptance, then the pointers are
// updated and the store is read into the result register; the result is then held
// until taken.
// overwriting_ring_buffer_top: depends on orb_pkg, orb_if, orb_ctrl, orb_dp
module overwriting_ring_buffer_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [orb_pkg::CAP_W-1:0] cfg_data,
  orb_in_if.sink                    item,
  orb_out_if.source                 result
);
  import orb_pkg::*;

  ctrl_t ctrl;

  orb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .ctrl      (ctrl)
  );

  orb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .command    (item.command),
    .push_value (item.push_value),
    .read_value (result.read_value),
    .underflow  (result.underflow),
    .overwrote  (result.overwrote),
    .fill_count (result.fill_count)
  );

endmodule
